// File: rtl/nrgp_pkg.sv
// shared types, character codes and helper functions for the nmea rmc/gsv line parser
package nrgp_pkg;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_A     = 8'h41;

    localparam logic [11:0] YEAR_BASE = 12'd2000;

    localparam int TDATA_W = 56;
    localparam int TUSER_W = 1;

    // token numbers that carry a value
    localparam logic [3:0] TOK_TIME = 4'd1;
    localparam logic [3:0] TOK_FIX  = 4'd2;
    localparam logic [3:0] TOK_SATS = 4'd3;
    localparam logic [3:0] TOK_DATE = 4'd9;

    // bit positions in the closed-token flags
    localparam int FLG_TIME = 0;
    localparam int FLG_FIX  = 1;
    localparam int FLG_DATE = 2;
    localparam int FLG_SATS = 3;

    typedef struct packed {
        logic        status;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        logic [6:0]  day;
        logic [6:0]  month;
        logic [11:0] year;
        logic        fix;
        logic [7:0]  sats;
    } result_t;

    // handshake between the input register and the parse core
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } in_word_t;

    // expected prefix character; gsv selects "$GPGSV," over "$GPRMC,"
    function automatic logic [7:0] prefix_char(input logic gsv, input logic [2:0] p);
        logic [7:0] ch;
        case (p)
            3'd0:    ch = 8'h24;
            3'd1:    ch = 8'h47;
            3'd2:    ch = 8'h50;
            3'd3:    ch = gsv ? 8'h47 : 8'h52;
            3'd4:    ch = gsv ? 8'h53 : 8'h4D;
            3'd5:    ch = gsv ? 8'h56 : 8'h43;
            3'd6:    ch = CH_COMMA;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // {valid, nibble} of a hex digit in either case
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h41 && c <= 8'h46)
            r = {1'b1, 4'(c - 8'h37)};
        else if (c >= 8'h61 && c <= 8'h66)
            r = {1'b1, 4'(c - 8'h57)};
        else
            r = 5'd0;
        return r;
    endfunction

    // two bcd digits to binary
    function automatic logic [6:0] bcd_to_bin(input logic [7:0] b);
        logic [7:0] v;
        v = 8'({4'd0, b[7:4]} * 8'd10) + {4'd0, b[3:0]};
        return v[6:0];
    endfunction

endpackage

// File: rtl/nmea_rmc_gsv_line_parser_unit.sv
// top level of the nmea rmc/gsv line parser
// Takes one ASCII character per word and gives one result word per newline. A
// character passes an input register, then the parse core updates prefix match,
// checksum and field capture; a newline commits the fields of an accepted line
// into the result register. One character per clock is sustained, but the input
// stalls only when a newline arrives while the result register still holds a
// word that has not been taken.
module nmea_rmc_gsv_line_parser_unit
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // rx_byte
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // hour_value, minute_value, second_value, day_value, month_value,
    // year_value, fix_valid, satellites_seen
    output logic [nrgp_pkg::TDATA_W-1:0] m_tdata,
    output logic [nrgp_pkg::TUSER_W-1:0] m_tuser    // status
);
    import nrgp_pkg::*;

    in_word_t word;
    result_t  res;
    logic     res_valid;
    logic     out_free;
    logic     advance;

    // a newline waits until the result register can take its word
    assign advance = word.valid && ((word.data != CH_NL) || out_free);

    nrgp_in_stage u_in
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .advance  (advance),
        .word     (word)
    );

    nrgp_parse_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .rx_byte   (word.data),
        .res_valid (res_valid),
        .res       (res)
    );

    nrgp_out_stage u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (res_valid),
        .res      (res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// File: rtl/nrgp_in_stage.sv
// input register that holds one received word until the parse core takes it
module nrgp_in_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // rx_byte
    input  logic              advance,
    output nrgp_pkg::in_word_t word
);
    import nrgp_pkg::*;

    logic       valid_reg;
    logic [7:0] data_reg;

    assign s_tready   = !valid_reg || advance;
    assign word.valid = valid_reg;
    assign word.data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            data_reg <= s_tdata;
        end
    end

endmodule

// File: rtl/nrgp_parse_core.sv
// per-character line state, checksum, field capture and commit on newline
module nrgp_parse_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        rx_byte,
    output logic              res_valid,
    output nrgp_pkg::result_t res
);
    import nrgp_pkg::*;

    typedef enum logic [1:0] {PH_BEFORE, PH_HI, PH_LO, PH_DONE} phase_t;

    logic [2:0]  pos_reg, pos_next;
    logic [1:0]  pfx_reg, pfx_next;          // bit 0 rmc, bit 1 gsv
    logic [3:0]  tok_reg, tok_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [7:0]  xor_reg, xor_next;
    phase_t      phase_reg, phase_next;
    logic        ck_ok_reg, ck_ok_next;
    logic [7:0]  rx_ck_reg, rx_ck_next;
    logic [23:0] tdig_reg, tdig_next;
    logic [6:0]  pday_reg, pday_next;
    logic [6:0]  pmon_reg, pmon_next;
    logic [6:0]  pyear_reg, pyear_next;
    logic        pfix_reg, pfix_next;
    logic [7:0]  psats_reg, psats_next;
    logic [3:0]  flags_reg, flags_next;
    logic        drun_reg, drun_next;
    logic        prun_reg, prun_next;
    logic [6:0]  hour_reg, hour_next;
    logic [6:0]  min_reg, min_next;
    logic [6:0]  sec_reg, sec_next;
    logic [6:0]  day_reg, day_next;
    logic [6:0]  mon_reg, mon_next;
    logic [6:0]  year_reg, year_next;
    logic        fix_reg, fix_next;
    logic [7:0]  sats_reg, sats_next;

    logic        is_nl;
    logic        dig;
    logic [3:0]  d;
    logic [4:0]  hv;
    logic [11:0] sats_wide;
    logic [6:0]  slot_mul;
    logic        pre, sum_ok, rmc_ok, gsv_ok;
    logic        status;

    assign is_nl = (rx_byte == CH_NL);
    assign dig   = (rx_byte >= 8'h30) && (rx_byte <= 8'h39);
    assign d     = dig ? rx_byte[3:0] : 4'd0;
    assign hv    = hex_val(rx_byte);

    assign pre    = (pos_reg == 3'd7);
    assign sum_ok = (phase_reg == PH_DONE) && ck_ok_reg && (rx_ck_reg == xor_reg);
    assign rmc_ok = pre && pfx_reg[0] && sum_ok;
    assign gsv_ok = pre && pfx_reg[1] && sum_ok;

    assign sats_wide = 12'({4'd0, psats_reg} * 12'd10) + {8'd0, d};

    always_comb
    begin
        // date slot picked by the character count
        case (cnt_reg[2:1])
            2'd0:    slot_mul = 7'(pday_reg * 7'd10);
            2'd1:    slot_mul = 7'(pmon_reg * 7'd10);
            default: slot_mul = 7'(pyear_reg * 7'd10);
        endcase
    end

    always_comb
    begin
        pos_next   = pos_reg;
        pfx_next   = pfx_reg;
        tok_next   = tok_reg;
        cnt_next   = cnt_reg;
        xor_next   = xor_reg;
        phase_next = phase_reg;
        ck_ok_next = ck_ok_reg;
        rx_ck_next = rx_ck_reg;
        tdig_next  = tdig_reg;
        pday_next  = pday_reg;
        pmon_next  = pmon_reg;
        pyear_next = pyear_reg;
        pfix_next  = pfix_reg;
        psats_next = psats_reg;
        flags_next = flags_reg;
        drun_next  = drun_reg;
        prun_next  = prun_reg;
        hour_next  = hour_reg;
        min_next   = min_reg;
        sec_next   = sec_reg;
        day_next   = day_reg;
        mon_next   = mon_reg;
        year_next  = year_reg;
        fix_next   = fix_reg;
        sats_next  = sats_reg;
        status     = 1'b0;

        if (is_nl)
        begin
            if (rmc_ok)
            begin
                if (flags_reg[FLG_TIME])
                begin
                    hour_next = bcd_to_bin(tdig_reg[23:16]);
                    min_next  = bcd_to_bin(tdig_reg[15:8]);
                    sec_next  = bcd_to_bin(tdig_reg[7:0]);
                end
                if (flags_reg[FLG_FIX])
                begin
                    fix_next = pfix_reg;
                end
                if (flags_reg[FLG_DATE])
                begin
                    day_next  = pday_reg;
                    mon_next  = pmon_reg;
                    year_next = pyear_reg;
                    status    = 1'b1;
                end
            end
            else if (gsv_ok && flags_reg[FLG_SATS])
            begin
                sats_next = psats_reg;
            end
            // start of a new line
            pos_next   = 3'd0;
            pfx_next   = 2'b11;
            tok_next   = 4'd0;
            cnt_next   = 3'd0;
            xor_next   = 8'd0;
            phase_next = PH_BEFORE;
            ck_ok_next = 1'b0;
            rx_ck_next = 8'd0;
            tdig_next  = 24'd0;
            pday_next  = 7'd0;
            pmon_next  = 7'd0;
            pyear_next = 7'd0;
            pfix_next  = 1'b0;
            psats_next = 8'd0;
            flags_next = 4'd0;
            drun_next  = 1'b1;
            prun_next  = 1'b0;
        end
        else
        begin
            if (!pre)
            begin
                if (rx_byte != prefix_char(1'b0, pos_reg)) pfx_next[0] = 1'b0;
                if (rx_byte != prefix_char(1'b1, pos_reg)) pfx_next[1] = 1'b0;
                pos_next = pos_reg + 3'd1;
            end

            // the leading '$' is outside the checksum
            if (pos_reg != 3'd0)
            begin
                case (phase_reg)
                    PH_BEFORE:
                    begin
                        if (rx_byte == CH_STAR)
                        begin
                            phase_next = PH_HI;
                            ck_ok_next = 1'b1;
                        end
                        else
                        begin
                            xor_next = xor_reg ^ rx_byte;
                        end
                    end
                    PH_HI:
                    begin
                        if (!hv[4]) ck_ok_next = 1'b0;
                        else        rx_ck_next = {hv[3:0], 4'd0};
                        phase_next = PH_LO;
                    end
                    PH_LO:
                    begin
                        if (!hv[4]) ck_ok_next = 1'b0;
                        else        rx_ck_next = rx_ck_reg | {4'd0, hv[3:0]};
                        phase_next = PH_DONE;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end

            if (rx_byte == CH_COMMA)
            begin
                case (tok_reg)
                    TOK_TIME: flags_next[FLG_TIME] = 1'b1;
                    TOK_FIX:  flags_next[FLG_FIX]  = 1'b1;
                    TOK_SATS: flags_next[FLG_SATS] = 1'b1;
                    TOK_DATE: flags_next[FLG_DATE] = 1'b1;
                    default:  flags_next = flags_reg;
                endcase
                if (tok_reg != 4'd15) tok_next = tok_reg + 4'd1;
                cnt_next  = 3'd0;
                drun_next = 1'b1;
                prun_next = 1'b0;
            end
            else
            begin
                case (tok_reg)
                    TOK_TIME:
                    begin
                        if (drun_reg && dig) tdig_next = {tdig_reg[19:0], d};
                        else                 drun_next = 1'b0;
                    end
                    TOK_FIX:
                    begin
                        if (cnt_reg == 3'd0) pfix_next = (rx_byte == CH_A);
                    end
                    TOK_SATS:
                    begin
                        if (drun_reg && dig)
                            psats_next = (sats_wide > 12'd255) ? 8'd255 : sats_wide[7:0];
                        else
                            drun_next = 1'b0;
                    end
                    TOK_DATE:
                    begin
                        if (cnt_reg < 3'd6)
                        begin
                            if (!cnt_reg[0])
                            begin
                                prun_next = dig;
                                case (cnt_reg[2:1])
                                    2'd0:    pday_next  = {3'd0, d};
                                    2'd1:    pmon_next  = {3'd0, d};
                                    default: pyear_next = {3'd0, d};
                                endcase
                            end
                            else if (prun_reg && dig)
                            begin
                                case (cnt_reg[2:1])
                                    2'd0:    pday_next  = slot_mul + {3'd0, d};
                                    2'd1:    pmon_next  = slot_mul + {3'd0, d};
                                    default: pyear_next = slot_mul + {3'd0, d};
                                endcase
                            end
                        end
                    end
                    default:
                    begin
                        drun_next = drun_reg;
                    end
                endcase
                if (cnt_reg != 3'd7) cnt_next = cnt_reg + 3'd1;
            end
        end
    end

    assign res_valid  = step && is_nl;
    assign res.status = status;
    assign res.hour   = hour_next;
    assign res.minute = min_next;
    assign res.second = sec_next;
    assign res.day    = day_next;
    assign res.month  = mon_next;
    assign res.year   = YEAR_BASE + {5'd0, year_next};
    assign res.fix    = fix_next;
    assign res.sats   = sats_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 3'd0;
            pfx_reg   <= 2'b11;
            tok_reg   <= 4'd0;
            cnt_reg   <= 3'd0;
            xor_reg   <= 8'd0;
            phase_reg <= PH_BEFORE;
            ck_ok_reg <= 1'b0;
            rx_ck_reg <= 8'd0;
            tdig_reg  <= 24'd0;
            pday_reg  <= 7'd0;
            pmon_reg  <= 7'd0;
            pyear_reg <= 7'd0;
            pfix_reg  <= 1'b0;
            psats_reg <= 8'd0;
            flags_reg <= 4'd0;
            drun_reg  <= 1'b1;
            prun_reg  <= 1'b0;
            hour_reg  <= 7'd0;
            min_reg   <= 7'd0;
            sec_reg   <= 7'd0;
            day_reg   <= 7'd0;
            mon_reg   <= 7'd0;
            year_reg  <= 7'd0;
            fix_reg   <= 1'b0;
            sats_reg  <= 8'd0;
        end
        else if (step)
        begin
            pos_reg   <= pos_next;
            pfx_reg   <= pfx_next;
            tok_reg   <= tok_next;
            cnt_reg   <= cnt_next;
            xor_reg   <= xor_next;
            phase_reg <= phase_next;
            ck_ok_reg <= ck_ok_next;
            rx_ck_reg <= rx_ck_next;
            tdig_reg  <= tdig_next;
            pday_reg  <= pday_next;
            pmon_reg  <= pmon_next;
            pyear_reg <= pyear_next;
            pfix_reg  <= pfix_next;
            psats_reg <= psats_next;
            flags_reg <= flags_next;
            drun_reg  <= drun_next;
            prun_reg  <= prun_next;
            hour_reg  <= hour_next;
            min_reg   <= min_next;
            sec_reg   <= sec_next;
            day_reg   <= day_next;
            mon_reg   <= mon_next;
            year_reg  <= year_next;
            fix_reg   <= fix_next;
            sats_reg  <= sats_next;
        end
    end

    // a newline always leaves a clean line state
    a_nl_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && is_nl |=> pos_reg == 3'd0 && tok_reg == 4'd0 && flags_reg == 4'd0)
        else $error("line state not cleared after newline");

    // star in the checksum region opens the digit phase
    a_star_phase: assert property (@(posedge clk) disable iff (!rst_n)
        step && rx_byte == CH_STAR && pos_reg != 3'd0 && phase_reg == PH_BEFORE
        |=> phase_reg == PH_HI && ck_ok_reg)
        else $error("star did not start checksum digits");

    // a decoded date only comes from a line that matched the rmc prefix
    a_status_rmc: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status |-> pre && pfx_reg[0] && flags_reg[FLG_DATE])
        else $error("status set without an rmc date token");

    // committed values move only on a newline
    a_commit_nl: assert property (@(posedge clk) disable iff (!rst_n)
        step && !is_nl |=> $stable(hour_reg) && $stable(day_reg) && $stable(sats_reg))
        else $error("committed value changed mid-line");

endmodule

// File: rtl/nrgp_out_stage.sv
// result register toward the downstream side
module nrgp_out_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  nrgp_pkg::result_t res,
    output logic              free,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [nrgp_pkg::TDATA_W-1:0] m_tdata,
    output logic [nrgp_pkg::TUSER_W-1:0] m_tuser
);
    import nrgp_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    assign free     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {res_reg.sats, res_reg.fix, res_reg.year, res_reg.month,
                       res_reg.day, res_reg.second, res_reg.minute, res_reg.hour};
    assign m_tuser  = res_reg.status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && free)
        begin
            res_reg <= res;
        end
    end

endmodule
